// ----- sv/fqom_pkg.sv -----
// fqom_pkg: shared constants, command/status codes, FSM state type and the
// controller/datapath interface structs for the FIFO quantity order matcher.
// No dependencies.
`timescale 1ns / 1ps

package fqom_pkg;

    // Field widths fixed by the stream format
    localparam int CMD_W  = 2;
    localparam int QTY_W  = 31;
    localparam int SUM_W  = 35;
    localparam int STAT_W = 2;

    // Default queue depth
    localparam int DEF_QUEUE_DEPTH = 16;

    // Command codes (code 3 is unused and changes no queue or market state)
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUY    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SELL   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_MATCH,
        S_DONE
    } fsm_state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;   // take the accepted input word
        logic rd;     // read both queue heads
        logic step;   // one match iteration on the read heads
        logic emit;   // capture the result into the output register
    } ctrl_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic can_match;  // market open and both queues non-empty
    } dp_status_t;

endpackage

// ----- sv/fifo_quantity_order_matcher_core.sv -----
// FIFO quantity order matcher, top level. An accepted input word triggers K
// match iterations (0 to about 2*QUEUE_DEPTH); each iteration is a head read
// plus an update on the queue memories, and the result is registered after
// the last one. A new word is taken only after the previous result is emitted;
// a pending result may wait in the output register while the next word is
// processed, and every cycle the receiver stalls after that holds off the next input word.
// Reset (rst_n, async low): queues empty, sell sum zero, market closed.
`timescale 1ns / 1ps

module fifo_quantity_order_matcher_core #(
    parameter int QUEUE_DEPTH = fqom_pkg::DEF_QUEUE_DEPTH,
    parameter int LVL_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int OUT_W       = ((2 * fqom_pkg::SUM_W + 1 + 2 * LVL_W + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,  // [30:0] quantity
    input  logic [fqom_pkg::CMD_W-1:0]  s_axis_tuser,  // [1:0] cmd
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [34:0] matched_quantity, [35] market_is_open, then buy_entries,
    // sell_entries (LVL_W each), sell_volume (35), zero pad
    output logic [OUT_W-1:0]            m_axis_tdata,
    output logic [fqom_pkg::STAT_W-1:0] m_axis_tuser   // [1:0] status
);
    import fqom_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t stat;

    // Sequencer
    fqom_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    // Queues and arithmetic
    fqom_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LVL_W       (LVL_W),
        .OUT_W       (OUT_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .in_cmd     (s_axis_tuser),
        .in_qty     (s_axis_tdata[QTY_W-1:0]),
        .out_status (m_axis_tuser),
        .out_data   (m_axis_tdata)
    );

endmodule

// ----- sv/fqom_dp.sv -----
// fqom_dp: datapath of the order matcher: both order queues (memories),
// head/level pointers, running sell sum, match arithmetic and result register.
// Depends on fqom_pkg.
`timescale 1ns / 1ps

module fqom_dp #(
    parameter int QUEUE_DEPTH = fqom_pkg::DEF_QUEUE_DEPTH,
    parameter int LVL_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int OUT_W       = ((2 * fqom_pkg::SUM_W + 1 + 2 * LVL_W + 7) / 8) * 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fqom_pkg::ctrl_cmd_t       ctrl,
    output fqom_pkg::dp_status_t      stat,
    input  logic [fqom_pkg::CMD_W-1:0] in_cmd,
    input  logic [fqom_pkg::QTY_W-1:0] in_qty,
    output logic [fqom_pkg::STAT_W-1:0] out_status,
    output logic [OUT_W-1:0]          out_data
);
    import fqom_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int PAD_W = OUT_W - (2 * SUM_W + 1 + 2 * LVL_W);

    // Queue storage
    logic [QTY_W-1:0] buy_mem  [QUEUE_DEPTH];
    logic [QTY_W-1:0] sell_mem [QUEUE_DEPTH];

    logic [IDX_W-1:0]  buy_head_reg, buy_head_next;
    logic [IDX_W-1:0]  sell_head_reg, sell_head_next;
    logic [LVL_W-1:0]  buy_lvl_reg, buy_lvl_next;
    logic [LVL_W-1:0]  sell_lvl_reg, sell_lvl_next;
    logic [SUM_W-1:0]  sell_sum_reg, sell_sum_next;
    logic              open_reg, open_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [SUM_W-1:0]  total_reg, total_next;
    logic [QTY_W-1:0]  buy_rd_reg, sell_rd_reg;
    logic [STAT_W-1:0] ostat_reg;
    logic [OUT_W-1:0]  odata_reg;

    logic              buy_we, sell_we;
    logic [IDX_W-1:0]  buy_waddr, sell_waddr;
    logic [QTY_W-1:0]  buy_wdata, sell_wdata;
    logic [IDX_W-1:0]  buy_tail, sell_tail;
    logic [QTY_W-1:0]  match_qty, buy_left, sell_left;

    // Tail index = (head + level) mod depth, level < depth when used
    function automatic logic [IDX_W-1:0] tail_idx(input logic [IDX_W-1:0] head,
                                                  input logic [LVL_W-1:0] lvl);
        logic [LVL_W:0] sum;
        sum = {{(LVL_W + 1 - IDX_W){1'b0}}, head} + {1'b0, lvl};
        if (sum >= (LVL_W + 1)'(QUEUE_DEPTH))
        begin
            sum = sum - (LVL_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign buy_tail  = tail_idx(buy_head_reg, buy_lvl_reg);
    assign sell_tail = tail_idx(sell_head_reg, sell_lvl_reg);

    // Match arithmetic on the registered head words
    assign match_qty = (buy_rd_reg < sell_rd_reg) ? buy_rd_reg : sell_rd_reg;
    assign buy_left  = buy_rd_reg - match_qty;
    assign sell_left = sell_rd_reg - match_qty;

    assign stat.can_match = open_reg && (buy_lvl_reg != '0) && (sell_lvl_reg != '0);

    // Next-state logic for pointers, sums and memory writes
    always_comb
    begin
        buy_head_next  = buy_head_reg;
        sell_head_next = sell_head_reg;
        buy_lvl_next   = buy_lvl_reg;
        sell_lvl_next  = sell_lvl_reg;
        sell_sum_next  = sell_sum_reg;
        open_next      = open_reg;
        status_next    = status_reg;
        total_next     = total_reg;
        buy_we         = 1'b0;
        sell_we        = 1'b0;
        buy_waddr      = buy_head_reg;
        sell_waddr     = sell_head_reg;
        buy_wdata      = buy_left;
        sell_wdata     = sell_left;

        if (ctrl.load)
        begin
            status_next = STAT_OK;
            total_next  = '0;
            unique case (in_cmd)
                CMD_TOGGLE:
                begin
                    open_next = ~open_reg;
                end
                CMD_BUY:
                begin
                    if (in_qty == '0)
                    begin
                        status_next = STAT_ZERO;
                    end
                    else if (buy_lvl_reg == LVL_W'(QUEUE_DEPTH))
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        buy_we       = 1'b1;
                        buy_waddr    = buy_tail;
                        buy_wdata    = in_qty;
                        buy_lvl_next = buy_lvl_reg + 1'b1;
                    end
                end
                CMD_SELL:
                begin
                    if (in_qty == '0)
                    begin
                        status_next = STAT_ZERO;
                    end
                    else if (sell_lvl_reg == LVL_W'(QUEUE_DEPTH))
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        sell_we       = 1'b1;
                        sell_waddr    = sell_tail;
                        sell_wdata    = in_qty;
                        sell_lvl_next = sell_lvl_reg + 1'b1;
                        sell_sum_next = sell_sum_reg + SUM_W'(in_qty);
                    end
                end
                default:
                begin
                    // unused command: no change
                end
            endcase
        end
        else if (ctrl.step)
        begin
            // write back the remainders, retire heads that reached zero
            buy_we        = 1'b1;
            sell_we       = 1'b1;
            sell_sum_next = sell_sum_reg - SUM_W'(match_qty);
            total_next    = total_reg + SUM_W'(match_qty);
            if (buy_left == '0)
            begin
                buy_head_next = next_idx(buy_head_reg);
                buy_lvl_next  = buy_lvl_reg - 1'b1;
            end
            if (sell_left == '0)
            begin
                sell_head_next = next_idx(sell_head_reg);
                sell_lvl_next  = sell_lvl_reg - 1'b1;
            end
        end
    end

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buy_head_reg  <= '0;
            sell_head_reg <= '0;
            buy_lvl_reg   <= '0;
            sell_lvl_reg  <= '0;
            sell_sum_reg  <= '0;
            open_reg      <= 1'b0;
        end
        else
        begin
            buy_head_reg  <= buy_head_next;
            sell_head_reg <= sell_head_next;
            buy_lvl_reg   <= buy_lvl_next;
            sell_lvl_reg  <= sell_lvl_next;
            sell_sum_reg  <= sell_sum_next;
            open_reg      <= open_next;
        end
    end

    // Per-item working registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        total_reg  <= total_next;
    end

    // Buy queue memory, registered read
    always_ff @(posedge clk)
    begin
        if (buy_we)
        begin
            buy_mem[buy_waddr] <= buy_wdata;
        end
        if (ctrl.rd)
        begin
            buy_rd_reg <= buy_mem[buy_head_reg];
        end
    end

    // Sell queue memory, registered read
    always_ff @(posedge clk)
    begin
        if (sell_we)
        begin
            sell_mem[sell_waddr] <= sell_wdata;
        end
        if (ctrl.rd)
        begin
            sell_rd_reg <= sell_mem[sell_head_reg];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            ostat_reg <= status_reg;
            odata_reg <= {{PAD_W{1'b0}}, sell_sum_reg, sell_lvl_reg, buy_lvl_reg,
                          open_reg, total_reg};
        end
    end

    assign out_status = ostat_reg;
    assign out_data   = odata_reg;

endmodule

// ----- sv/fqom_ctrl.sv -----
// fqom_ctrl: controller FSM of the order matcher: input/output handshakes and
// sequencing of the match loop over the datapath.
// Depends on fqom_pkg.
`timescale 1ns / 1ps

module fqom_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fqom_pkg::ctrl_cmd_t  ctrl,
    input  fqom_pkg::dp_status_t stat
);
    import fqom_pkg::*;

    fsm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        ctrl           = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.can_match)
                begin
                    ctrl.rd    = 1'b1;
                    state_next = S_MATCH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MATCH:
            begin
                ctrl.step  = 1'b1;
                state_next = S_CHECK;
            end
            S_DONE:
            begin
                // wait for the result register to be free
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.emit      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
